// ===== rtl/core/lds_pkg.sv =====
// Shared types, constants and key compare for the layer/depth sorter.
package lds_pkg;

	localparam int MAX_ENTRIES = 128;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic [15:0]        id;
		logic [7:0]         layer;
		logic signed [31:0] height;
	} entry_t;

	typedef struct packed {
		logic   load;
		logic   shift;
		entry_t new_entry;
	} cell_ctrl_t;

	// Layer on top, height with the sign flipped so an unsigned compare orders it.
	function automatic logic [39:0] sort_key(input entry_t e);
		sort_key = {e.layer, ~e.height[31], e.height[30:0]};
	endfunction

	function automatic logic key_gt(input entry_t a, input entry_t b);
		key_gt = sort_key(a) > sort_key(b);
	endfunction

endpackage

// ===== rtl/core/layer_depth_sort.sv =====
// Layer/depth sorter: insertion cell chain, reads shift the chain toward cell 0.
// Throughput: one beat per cycle on the input, loads and reads alike, except that the
// input stalls while a read result is held by result_stall.
// Latency: a read's result is registered and shows the cycle after acceptance.
// A load places its entry by parallel compare in every cell.
// Reset clears count and batch flags at once; cell contents need no clearing.
module layer_depth_sort
	import lds_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               mode,
	input  logic [15:0]        entity_id,
	input  logic [7:0]         layer,
	input  logic signed [31:0] height,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [15:0]        out_id,
	output logic [7:0]         out_layer,
	output logic signed [31:0] out_height,
	output logic               is_last,
	output logic               is_empty,
	output logic               overflowed
);

	logic [CNT_W-1:0] count_q;
	logic             draining_q;
	logic             overflow_q;
	logic             res_valid_q;

	entry_t           cell_entry [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] cell_gt;
	logic [MAX_ENTRIES-1:0] cell_occ;
	cell_ctrl_t       ctrl;

	logic accept;
	logic rd;
	logic ld;
	logic load_ok;
	logic empty;
	logic last;

	assign item_stall   = res_valid_q & result_stall;
	assign result_valid = res_valid_q;

	assign accept  = item_valid & ~item_stall;
	assign rd      = accept & (mode == MODE_READ);
	assign ld      = accept & (mode == MODE_LOAD);
	assign empty   = (count_q == '0);
	assign last    = (count_q == CNT_W'(1));
	assign load_ok = ld & ~draining_q & (count_q < CNT_W'(MAX_ENTRIES));

	always_comb begin
		ctrl.load            = load_ok;
		ctrl.shift           = rd & ~empty & ~last;
		ctrl.new_entry.id     = entity_id;
		ctrl.new_entry.layer  = layer;
		ctrl.new_entry.height = height;
	end

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_g;
		logic   prev_o;

		assign cell_occ[k] = (count_q > CNT_W'(k));

		if (k == 0) begin : g_head
			assign prev_e = '0;
			assign prev_g = 1'b0;
			assign prev_o = 1'b1;
		end else begin : g_body
			assign prev_e = cell_entry[k-1];
			assign prev_g = cell_gt[k-1];
			assign prev_o = cell_occ[k-1];
		end

		if (k == MAX_ENTRIES - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_mid
			assign next_e = cell_entry[k+1];
		end

		lds_cell u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.occupied      (cell_occ[k]),
			.prev_occupied (prev_o),
			.prev_gt       (prev_g),
			.prev_entry    (prev_e),
			.next_entry    (next_e),
			.entry         (cell_entry[k]),
			.gt            (cell_gt[k])
		);
	end

	// batch bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (rd) begin
			if (empty || last) begin
				count_q    <= '0;
				draining_q <= 1'b0;
				overflow_q <= 1'b0;
			end else begin
				count_q    <= count_q - CNT_W'(1);
				draining_q <= 1'b1;
			end
		end else if (ld) begin
			if (load_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rd) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			if (empty) begin
				out_id     <= '0;
				out_layer  <= '0;
				out_height <= '0;
				is_last    <= 1'b0;
				is_empty   <= 1'b1;
				overflowed <= 1'b0;
			end else begin
				out_id     <= cell_entry[0].id;
				out_layer  <= cell_entry[0].layer;
				out_height <= cell_entry[0].height;
				is_last    <= last;
				is_empty   <= 1'b0;
				overflowed <= overflow_q;
			end
		end
	end

endmodule

// ===== rtl/core/lds_cell.sv =====
// One slot of the sorted insertion chain.
module lds_cell
	import lds_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occupied,
	input  logic       prev_occupied,
	input  logic       prev_gt,
	input  entry_t     prev_entry,
	input  entry_t     next_entry,
	output entry_t     entry,
	output logic       gt
);

	entry_t entry_q;

	assign entry = entry_q;
	// Held entry sorts strictly after the incoming one; ties stay ahead.
	assign gt    = occupied & key_gt(entry_q, ctrl.new_entry);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (gt || !occupied) begin
				if (prev_gt) begin
					entry_q <= prev_entry;
				end else if (prev_occupied) begin
					entry_q <= ctrl.new_entry;
				end
			end
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== tb/sv/layer_depth_sort_test.sv =====
// Self-checking testbench for the layer/depth sorter: queued stimulus, sort predictor, checker.
`timescale 1ns / 1ps

module layer_depth_sort_test;
	import lds_pkg::*;

	typedef struct packed {
		logic   md;
		entry_t e;
	} beat_t;

	typedef struct packed {
		logic [15:0]        id;
		logic [7:0]         layer;
		logic signed [31:0] height;
		logic               last;
		logic               empty;
		logic               ovf;
	} read_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               mode = MODE_LOAD;
	logic [15:0]        entity_id = '0;
	logic [7:0]         layer = '0;
	logic signed [31:0] height = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [15:0]        out_id;
	logic [7:0]         out_layer;
	logic signed [31:0] out_height;
	logic               is_last;
	logic               is_empty;
	logic               overflowed;

	layer_depth_sort DUT (.*);

	beat_t        pending_beats[$];
	read_result_t expected_reads[$];

	// predictor state: the batch as it should sit in the cell chain
	entry_t sorted_batch[$];
	int     read_pos = 0;
	bit     draining = 1'b0;
	bit     overflow_seen = 1'b0;

	logic  in_took = 1'b0;
	logic  out_took = 1'b0;
	int    results_seen = 0;
	int    mismatches = 0;
	beat_t tx_beat;
	int    tx_gap = 0;
	int    rx_wait = 0;
	bit    tx_quiet = 1'b0;
	bit    rx_quiet = 1'b0;

	initial forever #5 clk = ~clk;

	// per-beat wait, with occasional runs of back-to-back beats
	function automatic int draw_wait(inout bit quiet);
		if ($urandom_range(0, 23) == 0)
			quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic entry_t any_entry();
		entry_t e;
		e.id = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: e.layer = 8'($urandom_range(0, 255));
			1: e.layer = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			default: e.layer = 8'($urandom_range(0, 3));
		endcase
		case ($urandom_range(0, 4))
			0: e.height = $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: e.height = 32'h8000_0000;
					1: e.height = 32'h7FFF_FFFF;
					2: e.height = 32'h0000_0000;
					default: e.height = 32'hFFFF_FFFF;
				endcase
			end
			// narrow integer heights so ties are common
			default: e.height = ($urandom_range(0, 6) - 3) * 65536;
		endcase
		return e;
	endfunction

	function automatic void push_load(entry_t e);
		pending_beats.push_back(beat_t'{md: MODE_LOAD, e: e});
	endfunction

	function automatic void push_read();
		pending_beats.push_back(beat_t'{md: MODE_READ, e: any_entry()});
	endfunction

	function automatic bit sorts_after(entry_t a, entry_t b);
		if (a.layer != b.layer)
			return a.layer > b.layer;
		return $signed(a.height) > $signed(b.height);
	endfunction

	function automatic void start_new_batch();
		sorted_batch.delete();
		read_pos = 0;
		draining = 1'b0;
		overflow_seen = 1'b0;
	endfunction

	task automatic track_beat(input logic md, input entry_t e);
		read_result_t r;
		int pos;
		if (md == MODE_LOAD) begin
			if (draining || sorted_batch.size() >= MAX_ENTRIES) begin
				overflow_seen = 1'b1;
			end else begin
				// stable: goes behind every entry with an equal key
				pos = 0;
				while (pos < sorted_batch.size() && !sorts_after(sorted_batch[pos], e))
					pos++;
				sorted_batch.insert(pos, e);
			end
		end else begin
			r = '0;
			if (sorted_batch.size() == 0) begin
				r.empty = 1'b1;
				start_new_batch();
			end else begin
				r.id = sorted_batch[read_pos].id;
				r.layer = sorted_batch[read_pos].layer;
				r.height = sorted_batch[read_pos].height;
				r.last = (read_pos + 1 == sorted_batch.size());
				r.ovf = overflow_seen;
				if (r.last) begin
					start_new_batch();
				end else begin
					draining = 1'b1;
					read_pos++;
				end
			end
			expected_reads.push_back(r);
		end
	endtask

	// driver: new beat at the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || in_took) begin
				if (tx_gap > 0) begin
					item_valid <= 1'b0;
					tx_gap--;
				end else if (pending_beats.size() != 0) begin
					tx_beat = pending_beats.pop_front();
					item_valid <= 1'b1;
					mode <= tx_beat.md;
					entity_id <= tx_beat.e.id;
					layer <= tx_beat.e.layer;
					height <= tx_beat.e.height;
					tx_gap = draw_wait(tx_quiet);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern, plus two long hold-offs to back up the input
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				rx_wait = draw_wait(rx_quiet);
				if (results_seen == 40 || results_seen == 200)
					rx_wait = 400;
			end
			if (rx_wait > 0) begin
				result_stall <= 1'b1;
				rx_wait--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// monitor: predict on every accepted input beat, then check any accepted result
	always @(posedge clk or negedge arst_n) begin
		read_result_t want;
		read_result_t got;
		if (!arst_n) begin
			in_took <= 1'b0;
			out_took <= 1'b0;
		end else begin
			in_took <= item_valid && !item_stall;
			out_took <= result_valid && !result_stall;
			if (item_valid && !item_stall)
				track_beat(mode, entry_t'{id: entity_id, layer: layer, height: height});
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				got = '{out_id, out_layer, out_height, is_last, is_empty, overflowed};
				if (expected_reads.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result id=%h layer=%0d height=%0d",
							$realtime, out_id, out_layer, out_height);
				end else begin
					want = expected_reads.pop_front();
					if (got.id !== want.id || got.layer !== want.layer
							|| got.height !== want.height || got.last !== want.last
							|| got.empty !== want.empty || got.ovf !== want.ovf) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch exp id=%h layer=%0d height=%0d last=%b ",
								"empty=%b ovf=%b | got id=%h layer=%0d height=%0d last=%b ",
								"empty=%b ovf=%b"}, $realtime,
								want.id, want.layer, want.height, want.last, want.empty,
								want.ovf, got.id, got.layer, got.height, got.last, got.empty,
								got.ovf);
					end
				end
			end
		end
	end

	initial begin
		int n;
		int stored;
		int cut;

		// directed: empty read, key extremes, ties, load while draining
		push_read();
		push_load(entry_t'{id: 16'h0000, layer: 8'd255, height: 32'h7FFF_FFFF});
		push_load(entry_t'{id: 16'hFFFF, layer: 8'd0, height: 32'h8000_0000});
		push_load(entry_t'{id: 16'h1234, layer: 8'd7, height: 32'h0000_0000});
		push_load(entry_t'{id: 16'h1235, layer: 8'd7, height: 32'h0000_0000});
		push_load(entry_t'{id: 16'h1236, layer: 8'd7, height: 32'hFFFF_FFFF});
		push_load(entry_t'{id: 16'h00FF, layer: 8'd255, height: 32'h8000_0000});
		push_load(entry_t'{id: 16'hFF00, layer: 8'd0, height: 32'h7FFF_FFFF});
		push_load(entry_t'{id: 16'h1237, layer: 8'd7, height: 32'h0000_0000});
		repeat (3) push_read();
		push_load(entry_t'{id: 16'hAAAA, layer: 8'd0, height: 32'h0000_0000});
		repeat (5) push_read();
		push_read();
		push_load(entry_t'{id: 16'h5555, layer: 8'd128, height: 32'h0001_8000});
		push_read();

		// full batch with dropped loads past capacity
		repeat (MAX_ENTRIES + 2) push_load(any_entry());
		repeat (MAX_ENTRIES) push_read();

		// random batches, mostly small; some broken by loads mid-drain, some followed by an extra empty read
		while (pending_beats.size() < 560) begin
			if ($urandom_range(0, 19) == 0)
				n = $urandom_range(MAX_ENTRIES - 2, MAX_ENTRIES + 3);
			else
				n = $urandom_range(0, 12);
			repeat (n) push_load(any_entry());
			stored = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
			if (stored > 1 && $urandom_range(0, 3) == 0) begin
				cut = $urandom_range(1, stored - 1);
				repeat (cut) push_read();
				repeat ($urandom_range(1, 3)) push_load(any_entry());
				repeat (stored - cut) push_read();
			end else begin
				repeat (stored) push_read();
			end
			if (stored == 0 || $urandom_range(0, 5) == 0)
				push_read();
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && expected_reads.size() == 0)
			$display("layer_depth_sort regression: pass");
		else
			$display("layer_depth_sort regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("layer_depth_sort regression: fail");
		$finish;
	end

endmodule
